[rtl/core/mf3_pkg.sv]
// Shared types, constants and register indexes of the 3x3 median filter.
`default_nettype none

package mf3_pkg;

  localparam int PIX_W          = 8;     // pixel width
  localparam int FW_W           = 11;    // line length register width
  localparam int FH_W           = 13;    // line count register width
  localparam int CFG_W          = 13;    // widest register
  localparam int CFG_IDX_W      = 1;
  localparam int CNT_W          = 13;    // width for frame geometry arithmetic
  localparam int MAX_LINE_DEF   = 1024;
  localparam int MIN_WIDTH      = 3;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int WIDTH_RST      = 640;
  localparam int HEIGHT_RST     = 480;
  localparam int OUT_DEPTH      = 8;     // result queue depth, also the in-flight limit

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [8:0][PIX_W-1:0] pix9_t;

  typedef struct packed {
    logic mode;
    pix_t pixel_in;
  } in_item_t;

  typedef struct packed {
    pix_t filtered;
    logic end_of_line;
    logic end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic eol;
    logic eof;
  } res_tag_t;

endpackage

`default_nettype wire

[rtl/core/mf3_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/mf3_median.sv]
// Three-stage median-of-nine network: column sort, row reduce, final median of three.
`default_nettype none

module mf3_median (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire mf3_pkg::pix9_t    in_win,
  input  wire mf3_pkg::res_tag_t in_tag,
  output logic                   out_valid,
  output mf3_pkg::pix_t          out_pix,
  output mf3_pkg::res_tag_t      out_tag
);
  import mf3_pkg::*;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  logic                   a_valid_r, b_valid_r, c_valid_r;
  pix9_t                  a_win_r;
  res_tag_t               a_tag_r, b_tag_r, c_tag_r;
  logic [2:0][PIX_W-1:0]  b_lo_r, b_mid_r, b_hi_r;
  logic [2:0][PIX_W-1:0]  lo_nxt, mid_nxt, hi_nxt;
  pix_t                   c_x_r, c_y_r, c_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  // sort each column of three
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_nxt[k]  = min2(min2(a_win_r[3*k], a_win_r[3*k+1]), a_win_r[3*k+2]);
      hi_nxt[k]  = max2(max2(a_win_r[3*k], a_win_r[3*k+1]), a_win_r[3*k+2]);
      mid_nxt[k] = med3(a_win_r[3*k], a_win_r[3*k+1], a_win_r[3*k+2]);
    end
  end

  always_ff @(posedge clk) begin
    a_win_r <= in_win;
    a_tag_r <= in_tag;
    b_lo_r  <= lo_nxt;
    b_mid_r <= mid_nxt;
    b_hi_r  <= hi_nxt;
    b_tag_r <= a_tag_r;
    c_x_r   <= max2(max2(b_lo_r[0], b_lo_r[1]), b_lo_r[2]);
    c_y_r   <= med3(b_mid_r[0], b_mid_r[1], b_mid_r[2]);
    c_z_r   <= min2(min2(b_hi_r[0], b_hi_r[1]), b_hi_r[2]);
    c_tag_r <= b_tag_r;
  end

  assign out_valid = c_valid_r;
  assign out_pix   = med3(c_x_r, c_y_r, c_z_r);
  assign out_tag   = c_tag_r;

endmodule

`default_nettype wire

[rtl/core/mf3_out_fifo.sv]
// Small register queue holding finished results until the receiver takes them.
`default_nettype none

module mf3_out_fifo #(
  parameter int DEPTH = mf3_pkg::OUT_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire mf3_pkg::out_item_t push_data,
  input  wire logic               pop,
  output logic                    valid,
  output mf3_pkg::out_item_t      data
);
  import mf3_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  out_item_t          slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0]   level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      level_r <= level_r + LVL_W'(push) - LVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign valid = (level_r != '0);
  assign data  = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

[rtl/core/median_filter_3x3_unit.sv]
// Streaming 3x3 median filter: line store RAM, window stage, median network and result queue.
//
// Pixels enter in raster order on the in_ channel (valid/stall); mode=1 marks a flush item,
// taken as a zero pixel. A frame of H lines by W pixels takes (H+1)*W+1 items and gives H*W
// results on the out_ channel, each the median of the zero-padded 3x3 neighbourhood, with
// end_of_line on the last result of a line and end_of_frame on the last of the frame.
// The result for a pixel is released by the item one line plus one pixel after it and passes
// through the line store stage, median network and result queue. One item is taken per cycle
// while in_stall is low. The line stores sit in one RAM read and written once per item; the
// only overlap, the first item of a frame reading the column just written, is forwarded.
// Items in flight plus queued results are limited to eight: in_stall rises at that count, so a
// receiver stalling for a while backs up the input after eight items, never earlier.
// Registers (cfg_we, cfg_index, cfg_wdata): 0 = line length (clamped to 3..MAX_LINE),
// 1 = line count (clamped to 1..4096). A write restarts the frame position and window.
// Reset sets 640 x 480, clears counters, window and queue; the line store RAM is not cleared,
// as every entry is written in a frame before it is read.
`default_nettype none

module median_filter_3x3_unit #(
  parameter int MAX_LINE = mf3_pkg::MAX_LINE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire mf3_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output mf3_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mf3_pkg::CFG_W-1:0]       cfg_wdata
);
  import mf3_pkg::*;

  localparam int COL_W = $clog2(MAX_LINE);
  localparam int OCC_W = $clog2(OUT_DEPTH + 1);
  localparam int WRD_W = 2 * PIX_W;

  // configuration
  logic [FW_W-1:0]  line_len_r;
  logic [FH_W-1:0]  line_cnt_r;
  logic [CNT_W-1:0] fw_ext, fh_ext, width_eff, height_eff;
  logic             cfg_restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= FW_W'(WIDTH_RST);
      line_cnt_r <= FH_W'(HEIGHT_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  line_len_r <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: line_cnt_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_restart = cfg_we;

  always_comb begin
    fw_ext = CNT_W'(line_len_r);
    fh_ext = CNT_W'(line_cnt_r);
    if (fw_ext < CNT_W'(MIN_WIDTH)) begin
      width_eff = CNT_W'(MIN_WIDTH);
    end else if (fw_ext > CNT_W'(MAX_LINE)) begin
      width_eff = CNT_W'(MAX_LINE);
    end else begin
      width_eff = fw_ext;
    end
    if (fh_ext == '0) begin
      height_eff = CNT_W'(1);
    end else if (fh_ext > CNT_W'(HEIGHT_LIMIT)) begin
      height_eff = CNT_W'(HEIGHT_LIMIT);
    end else begin
      height_eff = fh_ext;
    end
  end

  // frame position and accept stage
  logic [COL_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic             accept, pop, drop;
  logic             at_col0, at_eof;
  pix_t             pix_acc;

  assign accept  = in_valid & ~in_stall;
  assign at_col0 = (col_r == '0);
  assign at_eof  = at_col0 && (row_r == height_eff + CNT_W'(1));
  assign pix_acc = (!in_data.mode && (row_r < height_eff)) ? in_data.pixel_in : '0;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (at_eof) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (CNT_W'(col_r) + CNT_W'(1) == width_eff) begin
      col_nxt = '0;
      row_nxt = row_r + CNT_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store: {upper, lower} per column, read at accept, written back in the following cycle
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_addr_r;
  pix_t             s1_pix_r;
  logic             s1_col0_r, s1_ge1_r, s1_ge2_r, s1_eof_r;
  logic             s1_fwd_r;
  logic [WRD_W-1:0] s1_fwd_word_r;
  logic [WRD_W-1:0] ram_rdata, rd_word, wr_word;
  pix_t             rd_upper, rd_lower, top_pix, mid_pix;

  mf3_ram #(
    .WIDTH (WRD_W),
    .DEPTH (MAX_LINE)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (wr_word),
    .re    (accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r     <= col_r;
      s1_pix_r      <= pix_acc;
      s1_col0_r     <= at_col0;
      s1_ge1_r      <= (row_r != '0);
      s1_ge2_r      <= (row_r >= CNT_W'(2));
      s1_eof_r      <= at_eof;
      // forward the write-back when the new read hits the column being written
      s1_fwd_r      <= s1_valid_r && (s1_addr_r == col_r);
      s1_fwd_word_r <= wr_word;
    end
  end

  assign rd_word  = s1_fwd_r ? s1_fwd_word_r : ram_rdata;
  assign rd_upper = rd_word[WRD_W-1:PIX_W];
  assign rd_lower = rd_word[PIX_W-1:0];
  assign wr_word  = {rd_lower, s1_pix_r};
  assign top_pix  = s1_ge2_r ? rd_upper : '0;
  assign mid_pix  = s1_ge1_r ? rd_lower : '0;

  // window stage
  pix9_t    win_r, win_nxt, shifted, res_win;
  logic     has_res;
  res_tag_t res_tag;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      shifted[k] = win_r[k+3];
    end
    shifted[6] = top_pix;
    shifted[7] = mid_pix;
    shifted[8] = s1_pix_r;
    if (s1_col0_r) begin
      // last pixel of a line: right neighbour column lies outside
      res_win = '0;
      for (int k = 0; k < 6; k++) begin
        res_win[k] = win_r[k+3];
      end
      has_res     = s1_ge2_r;
      res_tag.eol = 1'b1;
      res_tag.eof = s1_eof_r;
      win_nxt     = '0;
      if (!s1_eof_r) begin
        win_nxt[6] = top_pix;
        win_nxt[7] = mid_pix;
        win_nxt[8] = s1_pix_r;
      end
    end else begin
      res_win     = shifted;
      has_res     = s1_ge1_r;
      res_tag.eol = 1'b0;
      res_tag.eof = 1'b0;
      win_nxt     = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // median network and result queue
  logic      med_valid;
  pix_t      med_pix;
  res_tag_t  med_tag;
  out_item_t med_item;

  mf3_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r && has_res),
    .in_win    (res_win),
    .in_tag    (res_tag),
    .out_valid (med_valid),
    .out_pix   (med_pix),
    .out_tag   (med_tag)
  );

  assign med_item = '{filtered: med_pix, end_of_line: med_tag.eol, end_of_frame: med_tag.eof};

  mf3_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (med_valid),
    .push_data (med_item),
    .pop       (pop),
    .valid     (out_valid),
    .data      (out_data)
  );

  // occupancy: items in flight plus queued results; drop items that give no result
  logic [OCC_W-1:0] occ_r;

  assign pop  = out_valid & ~out_stall;
  assign drop = s1_valid_r & ~has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + OCC_W'(accept) - OCC_W'(pop) - OCC_W'(drop);
    end
  end

  assign in_stall = (occ_r == OCC_W'(OUT_DEPTH));

endmodule

`default_nettype wire

[rtl/core/mf3_checker.sv]
// Port-level checker for the median filter, bound to the top level.
`default_nettype none

module mf3_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire mf3_pkg::out_item_t            out_data
);
  import mf3_pkg::*;

  // reset empties the block
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // back-pressure only builds up through input transfers
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("in_stall rose without an input transfer");

  // the end of a frame is also the end of a line
  a_eof_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_frame |-> out_data.end_of_line)
    else $error("end_of_frame without end_of_line");

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
